>>> rtl/zph_pkg.sv
`default_nettype none

package zph_pkg;

    localparam int SQUARES     = 64;
    localparam int KEY_ROWS    = 13;
    localparam int KEY_DEPTH   = KEY_ROWS * SQUARES;
    localparam int ADDR_W      = $clog2(KEY_DEPTH);
    localparam int FLAG_ROW    = 12;
    localparam int FLAG_BASE   = FLAG_ROW * SQUARES;
    localparam int FLAG_KEYS   = 13;
    localparam int FLAG_IDX_W  = $clog2(FLAG_KEYS);
    localparam int EMPTY_CODE  = 12;
    localparam int EP_KEY_BASE = 5;
    localparam int STM_KEY     = 0;
    localparam int CASTLE_KEY  = 1;

    localparam logic [63:0] SEED_VALUE = 64'h0000_0128_3712_7093;

    typedef logic [63:0]       key_t;
    typedef logic [ADDR_W-1:0] key_addr_t;

    // one xorshift(13,7,17) step
    function automatic key_t next_key(input key_t v);
        key_t t;
        begin
            t = v ^ (v << 13);
            t = t ^ (t >> 7);
            t = t ^ (t << 17);
            return t;
        end
    endfunction

endpackage

`default_nettype wire

>>> rtl/zobrist_position_hasher.sv
// Zobrist position hasher: one square per input transaction, hash out on tlast.
// Output: the last square passes the read stage, then its hash is loaded into the output register for m_axis.
// Throughput: one square per cycle, set by one key memory read and one XOR per square; once the
// sweep ends, the input stalls only while a last square in the read stage waits on an untaken hash.
// Reset: rst_n clears the accumulator and starts a key fill sweep over all 832 entries
// (one memory entry per cycle); s_axis_tready stays low until the sweep ends.
`default_nettype none

module zobrist_position_hasher
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    // square[5:0], piece_code[9:6], side_to_move[10], castle_rights[14:11],
    // ep_valid[15], ep_file[18:16], zero fill [23:19]
    input  wire logic [23:0]  s_axis_tdata,
    input  wire logic         s_axis_tlast,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // hash[63:0]
    output logic [63:0]       m_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready
);

    import zph_pkg::*;

    // key memory and fill sweep
    key_t      key_mem [KEY_DEPTH];
    key_t      flag_key_reg [FLAG_KEYS];
    key_t      fill_key_reg, fill_key_next;
    key_addr_t fill_cnt_reg;
    logic      fill_done;
    logic      fill_we;
    logic      fill_flag_we;

    // input field views
    logic [5:0] in_square;
    logic [3:0] in_piece_code;
    logic       in_side_to_move;
    logic [3:0] in_castle_rights;
    logic       in_ep_valid;
    logic [2:0] in_ep_file;
    logic       in_use_key;
    logic       in_accept;
    key_addr_t  rd_addr;
    key_t       flag_fold;
    logic [FLAG_IDX_W-1:0] ep_idx;

    // read stage
    key_t rd_data_reg;
    logic s1_valid_reg;
    logic s1_last_reg;
    logic s1_use_key_reg;
    key_t s1_flag_reg;
    logic s1_adv;
    key_t acc;

    // accumulator and output register
    key_t running_hash_reg;
    key_t hash_reg;
    logic out_valid_reg;

    // field unpacking
    assign in_square        = s_axis_tdata[5:0];
    assign in_piece_code    = s_axis_tdata[9:6];
    assign in_side_to_move  = s_axis_tdata[10];
    assign in_castle_rights = s_axis_tdata[14:11];
    assign in_ep_valid      = s_axis_tdata[15];
    assign in_ep_file       = s_axis_tdata[18:16];

    // fill sweep control
    assign fill_done     = (fill_cnt_reg == key_addr_t'(KEY_DEPTH));
    assign fill_we       = !fill_done;
    assign fill_key_next = next_key(fill_key_reg);
    assign fill_flag_we  = fill_we && (fill_cnt_reg >= key_addr_t'(FLAG_BASE))
                           && (fill_cnt_reg < key_addr_t'(FLAG_BASE + FLAG_KEYS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_cnt_reg <= '0;
            fill_key_reg <= SEED_VALUE;
        end
        else if (fill_we)
        begin
            fill_cnt_reg <= fill_cnt_reg + key_addr_t'(1);
            fill_key_reg <= fill_key_next;
        end
    end

    // flag row keys kept in registers so all of them can be folded at once
    always_ff @(posedge clk)
    begin
        if (fill_flag_we)
        begin
            flag_key_reg[FLAG_IDX_W'(fill_cnt_reg - key_addr_t'(FLAG_BASE))] <= fill_key_next;
        end
    end

    // handshake
    assign s_axis_tready = fill_done && (!s1_valid_reg || s1_adv);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign in_use_key    = (in_piece_code < 4'(EMPTY_CODE));
    assign rd_addr       = in_use_key ? key_addr_t'({in_piece_code, in_square}) : '0;

    // memory write during fill, registered read on accept
    always_ff @(posedge clk)
    begin
        if (fill_we)
        begin
            key_mem[fill_cnt_reg] <= fill_key_next;
        end
        if (in_accept)
        begin
            rd_data_reg <= key_mem[rd_addr];
        end
    end

    // fold of side, castling and en passant keys
    assign ep_idx = FLAG_IDX_W'(EP_KEY_BASE) + FLAG_IDX_W'(in_ep_file);

    always_comb
    begin
        flag_fold = '0;
        if (in_side_to_move)
        begin
            flag_fold = flag_fold ^ flag_key_reg[FLAG_IDX_W'(STM_KEY)];
        end
        for (int i = 0; i < 4; i++)
        begin
            if (in_castle_rights[i])
            begin
                flag_fold = flag_fold ^ flag_key_reg[FLAG_IDX_W'(CASTLE_KEY + i)];
            end
        end
        if (in_ep_valid)
        begin
            flag_fold = flag_fold ^ flag_key_reg[ep_idx];
        end
    end

    // read stage control
    assign s1_adv = s1_valid_reg && !(s1_last_reg && out_valid_reg && !m_axis_tready);
    assign acc    = running_hash_reg ^ (s1_use_key_reg ? rd_data_reg : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_last_reg  <= 1'b0;
        end
        else if (in_accept)
        begin
            s1_valid_reg <= 1'b1;
            s1_last_reg  <= s_axis_tlast;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_use_key_reg <= in_use_key;
            s1_flag_reg    <= flag_fold;
        end
    end

    // accumulator, cleared once a position is complete
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_hash_reg <= '0;
        end
        else if (s1_adv)
        begin
            running_hash_reg <= s1_last_reg ? '0 : acc;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv && s1_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_last_reg)
        begin
            hash_reg <= acc ^ s1_flag_reg;
        end
    end

    assign m_axis_tdata  = hash_reg;
    assign m_axis_tvalid = out_valid_reg;

    // checks
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_cnt_reg <= key_addr_t'(KEY_DEPTH))
        else $error("fill counter ran past the key memory");

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && s1_last_reg) |=> (running_hash_reg == '0))
        else $error("accumulator not cleared after a last square");

    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s1_valid_reg && s1_last_reg))
        else $error("result without a last square in the read stage");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_adv) |=> (s1_valid_reg && $stable(s1_flag_reg)
                                       && $stable(rd_data_reg)))
        else $error("stalled read stage lost its contents");

    a_no_accept_in_fill: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |-> !fill_we)
        else $error("square accepted while the key memory is being filled");

endmodule

`default_nettype wire
